// ----- rtl/scp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_pkg: shared types and constants of the spectral channel power block
// Holds the word layouts, accumulator limits, register indexes and the
// function that generates the log-sum correction table at elaboration.
// ----------------------------------------------------------------------------
package scp_pkg;

  // field widths
  localparam int unsigned BinW  = 13;
  localparam int unsigned AccW  = 14;
  localparam int unsigned CorrW = 6;
  localparam int unsigned CfgW  = 13;

  // accumulator saturation limits, 1/16 dB
  localparam logic signed [AccW-1:0] AccMin = -14'sd4096;
  localparam logic signed [AccW-1:0] AccMax = 14'sd8191;

  // fixed-point constants of the correction table
  localparam logic [63:0] StepQ31 = 64'd2116800189;  // 10^(-1/160) in Q31
  localparam logic [63:0] KQ24    = 64'd808071242;   // 160*log10(2) in Q24

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_LO_BIN    = 2'd0,
    CFG_HI_BIN    = 2'd1,
    CFG_BIN_COUNT = 2'd2
  } cfg_reg_e;

  // bin word after the input register
  typedef struct packed {
    logic signed [BinW-1:0] x;
    logic                   last;
    logic                   in_chan;
  } bin_item_t;

  // accumulator state after one bin
  typedef struct packed {
    logic signed [AccW-1:0] acc;
    logic                   started;
  } acc_state_t;

  // corr(d) = round(160*log10(1 + 10^(-d/160))), exact integer form,
  // evaluated at elaboration only
  function automatic logic [CorrW-1:0] corr_entry(input int unsigned d);
    logic [63:0] r;
    logic [63:0] y;
    logic [63:0] res;
    logic [63:0] p;
    int unsigned k;
    int          i;
    r = 64'd1 << 31;
    for (k = 0; k < d; k++) begin
      r = (r * StepQ31 + (64'd1 << 30)) >> 31;
    end
    y   = (64'd1 << 30) + ((r + 64'd1) >> 1);
    res = 64'd0;
    if (y >= (64'd2 << 30)) begin
      res = 64'd1 << 30;
      y   = y >> 1;
    end
    for (i = 1; i <= 30; i++) begin
      y = (y * y) >> 30;
      if (y >= (64'd2 << 30)) begin
        y   = y >> 1;
        res = res | (64'd1 << (30 - i));
      end
    end
    p = res * KQ24;
    p = (p + (64'd1 << 53)) >> 54;
    return p[CorrW-1:0];
  endfunction

endpackage

// ----- rtl/scp_bin_gate.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_bin_gate: bin index counter and input register
// Counts bins of a spectrum, decides channel membership of each bin and
// holds one bin word for the accumulator stage.
// ----------------------------------------------------------------------------
module scp_bin_gate
  import scp_pkg::*;
#(
  parameter int unsigned MAX_BINS = 4096
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic signed [BinW-1:0] in_x_i,
  input  logic                   in_last_i,
  input  logic [CfgW-2:0]        lo_bin_i,
  input  logic [CfgW-1:0]        hi_bin_i,
  input  logic [CfgW-1:0]        bin_count_i,
  input  logic                   advance_i,
  output logic                   item_valid_o,
  output bin_item_t              item_o
);

  localparam int unsigned IdxW = $clog2(MAX_BINS + 1);
  localparam int unsigned CmpW = (IdxW > CfgW) ? IdxW : CfgW;

  logic            vld_q, vld_d;
  bin_item_t       item_q;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [CmpW-1:0] idx_ext;
  logic            accept;
  logic            in_chan;

  assign in_ready_o = !vld_q || advance_i;
  assign accept     = in_valid_i && in_ready_o;

  // channel membership of the arriving bin
  assign idx_ext = CmpW'(idx_q);
  assign in_chan = (idx_ext >= CmpW'(lo_bin_i)) && (idx_ext <= CmpW'(hi_bin_i)) &&
                   (idx_ext < CmpW'(bin_count_i)) && (idx_q < IdxW'(MAX_BINS));

  // index counter, holds at the spectrum limit, clears after the last bin
  always_comb begin
    idx_d = idx_q;
    if (accept) begin
      if (in_last_i) begin
        idx_d = '0;
      end else if (idx_q < IdxW'(MAX_BINS)) begin
        idx_d = idx_q + IdxW'(1);
      end
    end
  end

  // word occupancy of the input register
  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (advance_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else begin
      vld_q <= vld_d;
      idx_q <= idx_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.x       <= in_x_i;
      item_q.last    <= in_last_i;
      item_q.in_chan <= in_chan;
    end
  end

  assign item_valid_o = vld_q;
  assign item_o       = item_q;

endmodule

// ----- rtl/scp_log_acc.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_log_acc: log-domain power accumulator
// acc = max(acc, x) + corr(|acc - x|), saturated, with the correction
// read from a constant table; the first bin of the channel loads acc.
// ----------------------------------------------------------------------------
module scp_log_acc
  import scp_pkg::*;
#(
  parameter int unsigned CORR_DEPTH = 512
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  bin_item_t  item_i,
  output acc_state_t next_o
);

  localparam int unsigned CorrAw = $clog2(CORR_DEPTH);

  logic [CorrW-1:0]        corr_tab [CORR_DEPTH];
  logic signed [AccW-1:0]  acc_q, acc_d;
  logic                    started_q, started_d;
  logic signed [AccW-1:0]  x_ext;
  logic signed [AccW:0]    diff;
  logic [AccW-1:0]         delta;
  logic signed [AccW-1:0]  hi;
  logic [CorrW-1:0]        corr;
  logic signed [AccW:0]    sum;
  logic signed [AccW-1:0]  sat;

  // correction table, constant
  for (genvar g = 0; g < CORR_DEPTH; g++) begin : g_corr
    assign corr_tab[g] = corr_entry(g);
  end

  // compare, distance and lookup
  assign x_ext = AccW'($signed(item_i.x));
  assign diff  = (AccW+1)'(acc_q) - (AccW+1)'(x_ext);
  assign hi    = diff[AccW] ? x_ext : acc_q;
  assign delta = diff[AccW] ? AccW'(-diff) : AccW'(diff);
  assign corr  = (delta < AccW'(CORR_DEPTH)) ? corr_tab[delta[CorrAw-1:0]] : '0;

  // add and saturate
  assign sum = (AccW+1)'(hi) + $signed({{(AccW+1-CorrW){1'b0}}, corr});
  always_comb begin
    if (sum > (AccW+1)'(AccMax)) begin
      sat = AccMax;
    end else if (sum < (AccW+1)'(AccMin)) begin
      sat = AccMin;
    end else begin
      sat = AccW'(sum);
    end
  end

  // accumulator after this bin
  always_comb begin
    acc_d     = acc_q;
    started_d = started_q;
    if (item_i.in_chan) begin
      started_d = 1'b1;
      acc_d     = started_q ? sat : x_ext;
    end
  end

  assign next_o.acc     = acc_d;
  assign next_o.started = started_d;

  // state registers, cleared after the last bin of a spectrum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= AccMin;
      started_q <= 1'b0;
    end else if (step_i) begin
      if (item_i.last) begin
        acc_q     <= AccMin;
        started_q <= 1'b0;
      end else begin
        acc_q     <= acc_d;
        started_q <= started_d;
      end
    end
  end

endmodule

// ----- rtl/spectral_channel_power_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectral_channel_power_top: log-domain channel power of a spectrum stream
// Sums the bins of one channel in 1/16 dB and reports the total with a
// range status on the last bin of each spectrum.
// ----------------------------------------------------------------------------
// The block takes one bin word per clock cycle and keeps that rate for any
// spectrum length. A bin word passes the input register, then the
// combinational accumulator stage (compare, subtract, table lookup, add and
// clamp), and the result lands in the output register as the word carrying
// tlast leaves the accumulator stage. Input only stalls when the next last
// bin reaches the accumulator while the previous result is still unread. Bins
// are counted from 0 after reset and after every tlast; a bin enters the sum
// when its index lies from the first channel bin (register 0) to the last
// channel bin (register 1) inclusive, below bin_count (register 2) and below
// MAX_BINS. tuser is 1 for an invalid range (first channel bin not below the
// last one, or last channel bin above bin_count), and tdata then reads
// -4096, as it does when no bin fell into the channel. Write the
// configuration registers only while no spectrum is in flight.
// ----------------------------------------------------------------------------
module spectral_channel_power_top
  import scp_pkg::*;
#(
  parameter int unsigned MAX_BINS   = 4096,
  parameter int unsigned CORR_DEPTH = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [12:0] cfg_data_i,
  // bin stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [12:0] bin_power_db, [15:13] zero
  input  logic        s_axis_tlast,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [13:0] channel_power_db, [15:14] zero
  output logic        m_axis_tuser    // [0] status
);

  logic [CfgW-2:0]        lo_bin_q;
  logic [CfgW-1:0]        hi_bin_q;
  logic [CfgW-1:0]        bin_count_q;
  logic                   item_valid;
  bin_item_t              item;
  acc_state_t             acc_next;
  logic                   advance;
  logic                   bad_range;
  logic                   out_valid_q, out_valid_d;
  logic                   out_status_q;
  logic signed [AccW-1:0] out_power_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_bin_q    <= '0;
      hi_bin_q    <= 13'd1;
      bin_count_q <= 13'd4096;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_LO_BIN:    lo_bin_q    <= cfg_data_i[CfgW-2:0];
        CFG_HI_BIN:    hi_bin_q    <= cfg_data_i;
        CFG_BIN_COUNT: bin_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register and bin index
  scp_bin_gate #(
    .MAX_BINS(MAX_BINS)
  ) u_bin_gate (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_x_i      (s_axis_tdata[BinW-1:0]),
    .in_last_i   (s_axis_tlast),
    .lo_bin_i    (lo_bin_q),
    .hi_bin_i    (hi_bin_q),
    .bin_count_i (bin_count_q),
    .advance_i   (advance),
    .item_valid_o(item_valid),
    .item_o      (item)
  );

  // accumulator stage
  scp_log_acc #(
    .CORR_DEPTH(CORR_DEPTH)
  ) u_log_acc (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(advance),
    .item_i(item),
    .next_o(acc_next)
  );

  // a last word needs a free output slot, other words always move on
  assign advance = item_valid && (!item.last || !out_valid_q || m_axis_tready);

  assign bad_range = (CfgW'(lo_bin_q) >= hi_bin_q) || (hi_bin_q > bin_count_q);

  // output register occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && item.last) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (advance && item.last) begin
      out_status_q <= bad_range;
      out_power_q  <= (bad_range || !acc_next.started) ? AccMin : acc_next.acc;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_power_q};
  assign m_axis_tuser  = out_status_q;

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for spectral_channel_power_top
// Streams spectra of bin levels into the block and checks every channel
// power word against an in-bench log-sum predictor with its own correction
// table. A directed table covers extremes, range errors and empty channels.
// Random phases follow, each with a new register setting, random bin levels,
// random idle bursts on both streams; one phase has a long result hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import scp_pkg::*;

  localparam int MaxBins     = 4096;
  localparam int CorrDepth   = 512;
  localparam int ItemTarget  = 1100;
  localparam int EarlyLen    = 30;
  localparam int SinkHold    = 80;
  localparam int DrainCycles = 8;
  localparam int CycleLimit  = 400000;

  // one channel power word
  typedef struct {
    logic                   status;
    logic signed [AccW-1:0] power;
  } chan_result_t;

  typedef enum {ROW_BIN, ROW_CFG} row_kind_e;

  // one row of the directed table
  typedef struct {
    row_kind_e kind;
    cfg_reg_e  addr;
    int        value;
    bit        last;
    bit        typed;
    bit        exp_status;
    int        exp_power;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        cfg_we = 1'b0;
  cfg_reg_e    cfg_addr = CFG_LO_BIN;
  logic [12:0] cfg_data = '0;

  logic        s_valid = 1'b0;
  logic [15:0] s_data = '0;
  logic        s_last = 1'b0;
  logic        s_ready;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [15:0] m_data;
  logic        m_user;

  // predictor state and its copy of the registers
  int  corr_tbl[CorrDepth];
  int  cfg_start = 0;
  int  cfg_stop = 1;
  int  cfg_count = 4096;
  int  pw_acc = -4096;
  bit  pw_started = 1'b0;
  int  bin_idx = 0;

  chan_result_t expected_powers[$];
  stim_row_t    dir_rows[$];

  // run bookkeeping
  int  mismatches = 0;
  int  n_results = 0;
  int  n_invalid = 0;
  int  n_saturated = 0;
  int  bins_sent = 0;
  int  rand_items = 0;
  int  cycles = 0;
  int  stall_cycles = 0;
  bit  src_idle = 1'b1;
  bit  sink_idle = 1'b1;
  bit  quiet_tail = 1'b0;
  bit  hold_req = 1'b0;

  spectral_channel_power_top DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user)
  );

  // clock, 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // correction table: Q31 powers of 10^(-1/160), Q30 log2, Q24 scale
  initial begin : corr_table_init
    longint unsigned ratio;
    longint unsigned y;
    longint unsigned lg;
    int d;
    int i;
    ratio = 64'd1 << 31;
    for (d = 0; d < CorrDepth; d++) begin
      y  = (64'd1 << 30) + ((ratio + 64'd1) >> 1);
      lg = 0;
      if (y >= (64'd2 << 30)) begin
        lg = 64'd1 << 30;
        y  = y >> 1;
      end
      for (i = 1; i <= 30; i++) begin
        y = (y * y) >> 30;
        if (y >= (64'd2 << 30)) begin
          y  = y >> 1;
          lg = lg | (64'd1 << (30 - i));
        end
      end
      corr_tbl[d] = int'((lg * KQ24 + (64'd1 << 53)) >> 54);
      ratio = (ratio * StepQ31 + (64'd1 << 30)) >> 31;
    end
  end

  // log-sum of one bin into the channel, result queued on last
  function automatic void sum_bin_power(input int x, input bit lst);
    int hi;
    int d;
    int s;
    bit bad;
    chan_result_t r;
    if (bin_idx >= cfg_start && bin_idx <= cfg_stop && bin_idx < cfg_count &&
        bin_idx < MaxBins) begin
      if (!pw_started) begin
        pw_acc     = x;
        pw_started = 1'b1;
      end else begin
        hi = (pw_acc > x) ? pw_acc : x;
        d  = (pw_acc > x) ? pw_acc - x : x - pw_acc;
        s  = hi + ((d < CorrDepth) ? corr_tbl[d] : 0);
        if (s > int'(AccMax)) s = int'(AccMax);
        if (s < int'(AccMin)) s = int'(AccMin);
        pw_acc = s;
      end
    end
    if (bin_idx < MaxBins) bin_idx++;
    if (lst) begin
      bad      = (cfg_start >= cfg_stop) || (cfg_stop > cfg_count);
      r.status = bad;
      r.power  = (bad || !pw_started) ? AccMin : pw_acc[AccW-1:0];
      expected_powers.push_back(r);
      n_results++;
      if (bad) n_invalid++;
      if (r.power == AccMax) n_saturated++;
      pw_acc     = int'(AccMin);
      pw_started = 1'b0;
      bin_idx    = 0;
    end
  endfunction

  function automatic void add_bin(input int v, input bit lst, input bit typed = 1'b0,
                                  input bit st = 1'b0, input int pw = 0);
    stim_row_t r;
    r.kind = ROW_BIN;
    r.addr = CFG_LO_BIN;
    r.value = v;
    r.last = lst;
    r.typed = typed;
    r.exp_status = st;
    r.exp_power = pw;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_cfg(input cfg_reg_e a, input int v);
    stim_row_t r;
    r.kind = ROW_CFG;
    r.addr = a;
    r.value = v;
    r.last = 1'b0;
    r.typed = 1'b0;
    r.exp_status = 1'b0;
    r.exp_power = 0;
    dir_rows.push_back(r);
  endfunction

  function automatic void report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", what);
  endfunction

  // offer one bin word, predict once it is taken
  task automatic send_bin(input logic [BinW-1:0] v, input bit lst);
    if (src_idle && !quiet_tail && $urandom_range(0, 4) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {3'b000, v};
    s_last  <= lst;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    @(negedge clk);
    sum_bin_power($signed(v), lst);
    bins_sent++;
  endtask

  // stop offering and let the block go idle
  task automatic settle();
    s_valid <= 1'b0;
    while (expected_powers.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e a, input int v);
    cfg_we   <= 1'b1;
    cfg_addr <= a;
    cfg_data <= v[12:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    case (a)
      CFG_LO_BIN:    cfg_start = v & 'hFFF;
      CFG_HI_BIN:    cfg_stop  = v & 'h1FFF;
      CFG_BIN_COUNT: cfg_count = v & 'h1FFF;
      default: ;
    endcase
    @(negedge clk);
  endtask

  function automatic int pick_level(input int mode, input int base);
    int t;
    case (mode)
      0: t = int'($urandom_range(0, 8191)) - 4096;
      1: begin
        t = base + int'($urandom_range(0, 80)) - 40;
        if (t > 4095) t = 4095;
        if (t < -4096) t = -4096;
      end
      2: t = int'($urandom_range(3900, 4095));
      default: t = -4096 + int'($urandom_range(0, 40));
    endcase
    return t;
  endfunction

  // result side: idle bursts and one long hold-off
  initial begin : result_sink
    int gap;
    gap = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_ready <= 1'b0;
        repeat (SinkHold) @(negedge clk);
        hold_req = 1'b0;
        m_ready <= 1'b1;
      end else if (gap > 0) begin
        m_ready <= 1'b0;
        gap--;
      end else if (sink_idle && !quiet_tail && $urandom_range(0, 4) == 0) begin
        m_ready <= 1'b0;
        gap = $urandom_range(0, 2);
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  // compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    chan_result_t want;
    logic signed [AccW-1:0] got_power;
    if (rst_n && m_valid && m_ready) begin
      got_power = m_data[AccW-1:0];
      if (expected_powers.size() == 0) begin
        report_mismatch($sformatf("unexpected word status=%0d power=%0d",
                                  m_user, got_power));
      end else begin
        want = expected_powers.pop_front();
        if (m_user !== want.status)
          report_mismatch($sformatf("status expected %0d got %0d", want.status, m_user));
        if (got_power !== want.power)
          report_mismatch($sformatf("channel power expected %0d got %0d",
                                    want.power, got_power));
      end
    end
  end

  // cycle limit and input stall count
  always @(posedge clk) begin
    cycles++;
    if (s_valid && !s_ready) stall_cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("** spectral_channel_power_top: FAILED **");
      $finish;
    end
  end

  // stimulus
  initial begin : stimulus
    stim_row_t row;
    int phase;
    int sp;
    int k;
    int len;
    int n_spec;
    int mode;
    int base;
    int sel;
    int start;
    int stop;
    int count;
    int base_len;

    // directed table, reset setting is start 0, stop 1, count 4096
    add_bin(-4096, 1'b1, 1'b1, 1'b0, -4096);
    add_bin(4095, 1'b1, 1'b1, 1'b0, 4095);
    add_bin(0, 1'b0);
    add_bin(0, 1'b1);
    add_bin(4095, 1'b0);
    add_bin(-4096, 1'b1, 1'b1, 1'b0, 4095);   // difference beyond table, no correction
    add_bin(100, 1'b0);
    add_bin(90, 1'b0);
    add_bin(-1, 1'b1);
    add_cfg(CFG_HI_BIN, 0);                    // start equals stop
    add_bin(77, 1'b1, 1'b1, 1'b1, -4096);
    add_cfg(CFG_HI_BIN, 4096);
    add_cfg(CFG_LO_BIN, 4095);                 // channel never reached
    add_bin(5, 1'b0);
    add_bin(6, 1'b1, 1'b1, 1'b0, -4096);
    add_cfg(CFG_LO_BIN, 2);
    add_cfg(CFG_BIN_COUNT, 3);                 // stop past the spectrum
    add_bin(1, 1'b1, 1'b1, 1'b1, -4096);
    add_cfg(CFG_LO_BIN, 1);
    add_cfg(CFG_HI_BIN, 3);                    // last channel bin cut by count
    add_bin(10, 1'b0);
    add_bin(20, 1'b0);
    add_bin(30, 1'b0);
    add_bin(40, 1'b1);
    add_cfg(CFG_BIN_COUNT, 0);
    add_bin(3, 1'b1, 1'b1, 1'b1, -4096);

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_CFG) begin
        settle();
        write_reg(row.addr, row.value);
      end else begin
        send_bin(row.value[BinW-1:0], row.last);
        if (row.typed) begin
          expected_powers[expected_powers.size()-1].status = row.exp_status;
          expected_powers[expected_powers.size()-1].power  = AccW'(row.exp_power);
        end
      end
    end

    // random phases, each with its own register setting
    phase = 0;
    while (rand_items < ItemTarget) begin
      settle();
      sel = $urandom_range(0, 9);
      if (phase == 0) begin
        count = 160;
        start = $urandom_range(0, 5);
        stop  = $urandom_range(120, 160);
      end else if (sel == 0) begin
        start = $urandom_range(0, 1) ? 4095 : 0;
        case ($urandom_range(0, 2))
          0: stop = 0;
          1: stop = 1;
          default: stop = 4096;
        endcase
        count = $urandom_range(0, 1) ? 4096 : 0;
      end else if (sel == 1) begin
        start = $urandom_range(0, 4095);
        stop  = $urandom_range(0, 4096);
        count = $urandom_range(0, 4096);
      end else begin
        count = (sel == 2) ? $urandom_range(100, 300) : $urandom_range(1, 40);
        stop  = $urandom_range(1, count);
        start = $urandom_range(0, stop - 1);
      end
      write_reg(CFG_LO_BIN, start);
      write_reg(CFG_HI_BIN, stop);
      write_reg(CFG_BIN_COUNT, count);

      src_idle  = $urandom_range(0, 3) != 0;
      sink_idle = $urandom_range(0, 3) != 0;
      n_spec    = $urandom_range(2, 6);
      // hold the result side while short spectra keep coming
      if (phase == 2) begin
        hold_req = 1'b1;
        n_spec   = 10;
      end
      base_len = (count >= 1 && count <= 400) ? count : $urandom_range(1, 64);

      for (sp = 0; sp < n_spec; sp++) begin
        // sender waits for every pending word once
        if (phase == 4 && sp == 1) begin
          s_valid <= 1'b0;
          while (expected_powers.size() != 0) @(negedge clk);
        end
        case ($urandom_range(0, 9))
          0: len = 1;
          1: len = $urandom_range(1, base_len * 2 + 2);
          default: len = base_len;
        endcase
        if (phase == 2) len = $urandom_range(1, 2);
        // short spectra early so the pressure phases fit in the item budget
        if (phase < 5 && len > EarlyLen) len = EarlyLen;
        if (len > ItemTarget - rand_items)
          len = (rand_items < ItemTarget) ? ItemTarget - rand_items : 1;
        mode = (phase == 0) ? 2 : $urandom_range(0, 3);
        base = int'($urandom_range(0, 8191)) - 4096;
        for (k = 0; k < len; k++) begin
          send_bin(BinW'(pick_level(mode, base)), k == len - 1);
        end
        rand_items += len;
        quiet_tail = rand_items >= ItemTarget - 150;
      end
      phase++;
    end

    settle();
    $display("covered %0d bins in %0d spectra, %0d with invalid range, %0d saturated",
             bins_sent, n_results, n_invalid, n_saturated);
    $display("input held off for %0d cycles over %0d random phases", stall_cycles, phase);
    if (mismatches == 0) begin
      $display("** spectral_channel_power_top: PASSED **");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("** spectral_channel_power_top: FAILED **");
    end
    $finish;
  end

endmodule
